FILE: sv/ray_triangle_intersect_top_assert.svh
`ifndef RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication, sampled on the block clock
`define RTI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rti assertion failed");

// next-cycle implication, sampled on the block clock
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rti assertion failed");

`endif

FILE: sv/rti_pkg.sv
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // internal fixed-point word and full product width
  localparam int IW = 64;
  localparam int PW = 2 * IW;

  typedef logic signed [IW-1:0] s64_t;
  typedef logic signed [PW-1:0] s128_t;

  localparam s64_t SMAX = {1'b0, {(IW-1){1'b1}}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic REG_DET_EPS = 1'b0;
  localparam logic REG_T_EPS   = 1'b1;

  localparam int EPS_W = 16;

  // saturate to the symmetric range
  function automatic s64_t sat_add(s64_t a, s64_t b);
    logic signed [IW:0] s;
    s = (IW+1)'(a) + (IW+1)'(b);
    if (s > (IW+1)'(SMAX)) return SMAX;
    if (s < -(IW+1)'(SMAX)) return -SMAX;
    return IW'(s);
  endfunction

  function automatic s64_t sat_sub(s64_t a, s64_t b);
    return sat_add(a, -b);
  endfunction

  // floor shift of the exact product, then saturate
  function automatic s64_t mulq_sat(s128_t p, int unsigned frac);
    s128_t sh;
    sh = p >>> frac;
    if (sh > PW'(SMAX)) return SMAX;
    if (sh < -PW'(SMAX)) return -SMAX;
    return IW'(sh);
  endfunction

endpackage

FILE: sv/rti_mul.sv
module rti_mul import rti_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output s128_t                p_o
);

  localparam int HW = IW / 2;

  s64_t a64, b64;
  logic signed [HW-1:0] ah, bh;
  logic signed [HW:0]   al, bl;

  logic signed [2*HW-1:0] hh_q;
  logic signed [2*HW:0]   hl_q, lh_q;
  logic signed [2*HW+1:0] ll_q;
  s128_t                  p_q;

  assign a64 = IW'(a_i);
  assign b64 = IW'(b_i);
  assign ah  = a64[IW-1:HW];
  assign bh  = b64[IW-1:HW];
  assign al  = {1'b0, a64[HW-1:0]};
  assign bl  = {1'b0, b64[HW-1:0]};

  // four half-width partial products, then one weighted sum
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hh_q <= ah * bh;
      hl_q <= ah * bl;
      lh_q <= al * bh;
      ll_q <= al * bl;
    end
    if (en_i[1]) begin
      p_q <= (PW'(hh_q) <<< IW) + (PW'(hl_q) <<< HW) + (PW'(lh_q) <<< HW) + PW'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

FILE: sv/ray_triangle_intersect_top.sv
// Moller-Trumbore ray/triangle test, signed fixed point with FRAC_BITS fraction bits.
// A load word (tuser 0) stores the ray origin (p0) and direction (p1) at once and
// gives no result; a test word (tuser 1) carries three vertices and gives one result
// word: tuser = hit, tdata = hit point x, y, z (all zero on a miss). The pipeline takes
// one word per cycle while the output is not stalled. A test word passes through two
// rounds of split multipliers for the cross and dot products, the 63-stage restoring
// divider for t, one quotient bit per stage, and one more round for the hit point.
// Test words use the ray that was loaded before them. Registers det_epsilon (0x0) and
// t_epsilon (0x4) are to be written by the user only while the block is idle; the
// block itself does not enforce this.
module ray_triangle_intersect_top import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int InTw  = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OutTw = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
  input  logic [InTw-1:0]  s_axis_tdata,
  // cmd
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit_x, hit_y, hit_z
  output logic [OutTw-1:0] m_axis_tdata,
  // hit
  output logic             m_axis_tuser,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int C  = COORD_WIDTH;
  localparam int EW = C + 1;

  localparam int S_IN  = 0;
  localparam int S_CM1 = 1;
  localparam int S_CM2 = 2;
  localparam int S_CQ  = 3;
  localparam int S_HQ  = 4;
  localparam int S_DM1 = 5;
  localparam int S_DM2 = 6;
  localparam int S_DQ  = 7;
  localparam int S_DA  = 8;
  localparam int S_DT  = 9;
  localparam int S_CK  = 10;
  localparam int S_DV0 = 11;
  localparam int NDIV  = IW - 1;
  localparam int S_FM1 = S_DV0 + NDIV;
  localparam int S_FM2 = S_FM1 + 1;
  localparam int S_FQ  = S_FM2 + 1;
  localparam int S_OUT = S_FQ + 1;
  localparam int NST   = S_OUT + 1;

  localparam s64_t CMAX_W = (IW'(1) <<< (C - 1)) - IW'(1);
  localparam s64_t CMIN_W = -CMAX_W - IW'(1);

  typedef struct packed {
    logic [2:0][EW-1:0] e1;
    logic [2:0][EW-1:0] e2;
    logic [2:0][EW-1:0] s;
  } geo_t;

  typedef struct packed {
    logic [2:0][C-1:0] org;
    logic [2:0][C-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic          miss;
    logic          sat;
    logic [IW-2:0] det;
    logic [IW-2:0] tn;
    logic [IW-1:0] rem;
    logic [IW-2:0] q;
  } div_t;

  // ---------------- configuration ----------------
  logic [EPS_W-1:0] det_eps_q, t_eps_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_eps_q <= '0;
      t_eps_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DET_EPS: det_eps_q <= pwdata[EPS_W-1:0];
        REG_T_EPS:   t_eps_q   <= pwdata[EPS_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DET_EPS: prdata = 32'(det_eps_q);
      REG_T_EPS:   prdata = 32'(t_eps_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------- stage control ----------------
  logic [NST-1:0] v_q, v_d, en;
  logic           in_word;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[S_IN];
  assign in_word       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    v_d = v_q;
    if (en[S_IN]) v_d[S_IN] = in_word && (s_axis_tuser == CMD_TEST);
    for (int k = 1; k < NST; k++) begin
      if (en[k]) v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  // ---------------- ray state ----------------
  ray_t ray_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_r_q <= '0;
    end else if (in_word && (s_axis_tuser == CMD_LOAD)) begin
      for (int i = 0; i < 3; i++) begin
        ray_r_q.org[i] <= s_axis_tdata[i*C +: C];
        ray_r_q.dir[i] <= s_axis_tdata[(3+i)*C +: C];
      end
    end
  end

  // ---------------- input stage: edges ----------------
  geo_t geo_d;
  geo_t geo_q [S_HQ+1];
  ray_t ray_q [S_FQ+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_d.e1[i] = EW'($signed(s_axis_tdata[(3+i)*C +: C])) -
                    EW'($signed(s_axis_tdata[i*C +: C]));
      geo_d.e2[i] = EW'($signed(s_axis_tdata[(6+i)*C +: C])) -
                    EW'($signed(s_axis_tdata[i*C +: C]));
      geo_d.s[i]  = EW'($signed(ray_r_q.org[i])) - EW'($signed(s_axis_tdata[i*C +: C]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_IN]) begin
      geo_q[S_IN] <= geo_d;
      ray_q[S_IN] <= ray_r_q;
    end
    for (int k = 1; k <= S_HQ; k++) begin
      if (en[k]) geo_q[k] <= geo_q[k-1];
    end
    for (int k = 1; k <= S_FQ; k++) begin
      if (en[k]) ray_q[k] <= ray_q[k-1];
    end
  end

  // ---------------- cross products h = dir x e2, q = s x e1 ----------------
  s128_t hp_p [3][2];
  s128_t qp_p [3][2];
  s64_t  hp_q [3][2];
  s64_t  qp_q [3][2];
  s64_t  h_q [3];
  s64_t  q_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_cross
    localparam int RA = (r + 1) % 3;
    localparam int RB = (r + 2) % 3;
    rti_mul #(.AW(EW), .BW(EW)) u_h0 (
      .clk_i, .en_i({en[S_CM2], en[S_CM1]}),
      .a_i(EW'($signed(ray_q[S_IN].dir[RA]))), .b_i(geo_q[S_IN].e2[RB]),
      .p_o(hp_p[r][0])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_h1 (
      .clk_i, .en_i({en[S_CM2], en[S_CM1]}),
      .a_i(EW'($signed(ray_q[S_IN].dir[RB]))), .b_i(geo_q[S_IN].e2[RA]),
      .p_o(hp_p[r][1])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_q0 (
      .clk_i, .en_i({en[S_CM2], en[S_CM1]}),
      .a_i(geo_q[S_IN].s[RA]), .b_i(geo_q[S_IN].e1[RB]),
      .p_o(qp_p[r][0])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_q1 (
      .clk_i, .en_i({en[S_CM2], en[S_CM1]}),
      .a_i(geo_q[S_IN].s[RB]), .b_i(geo_q[S_IN].e1[RA]),
      .p_o(qp_p[r][1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[S_CQ]) begin
      for (int r = 0; r < 3; r++) begin
        for (int m = 0; m < 2; m++) begin
          hp_q[r][m] <= mulq_sat(hp_p[r][m], FRAC_BITS);
          qp_q[r][m] <= mulq_sat(qp_p[r][m], FRAC_BITS);
        end
      end
    end
    if (en[S_HQ]) begin
      for (int r = 0; r < 3; r++) begin
        h_q[r] <= sat_sub(hp_q[r][0], hp_q[r][1]);
        q_q[r] <= sat_sub(qp_q[r][0], qp_q[r][1]);
      end
    end
  end

  // ---------------- dots: det, un, vn, tn ----------------
  logic [EW-1:0] da_op [4][3];
  s64_t          db_op [4][3];
  s128_t         dp_p [4][3];
  s64_t          dp_q [4][3];
  s64_t          dsum_q [4];
  s64_t          dlast_q [4];
  s64_t          dt_q [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da_op[0][i] = geo_q[S_HQ].e1[i];
      da_op[1][i] = geo_q[S_HQ].s[i];
      da_op[2][i] = EW'($signed(ray_q[S_HQ].dir[i]));
      da_op[3][i] = geo_q[S_HQ].e2[i];
      db_op[0][i] = h_q[i];
      db_op[1][i] = h_q[i];
      db_op[2][i] = q_q[i];
      db_op[3][i] = q_q[i];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_term
      rti_mul #(.AW(EW), .BW(IW)) u_mul (
        .clk_i, .en_i({en[S_DM2], en[S_DM1]}),
        .a_i(da_op[j][i]), .b_i(db_op[j][i]),
        .p_o(dp_p[j][i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_DQ]) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 3; i++) dp_q[j][i] <= mulq_sat(dp_p[j][i], FRAC_BITS);
      end
    end
    if (en[S_DA]) begin
      for (int j = 0; j < 4; j++) begin
        dsum_q[j]  <= sat_add(dp_q[j][0], dp_q[j][1]);
        dlast_q[j] <= dp_q[j][2];
      end
    end
    if (en[S_DT]) begin
      for (int j = 0; j < 4; j++) dt_q[j] <= sat_add(dsum_q[j], dlast_q[j]);
    end
  end

  // ---------------- checks and divider setup ----------------
  div_t dv_q [NDIV+1];
  div_t ck_d;
  s64_t det_a, un_a, vn_a, tn_a;

  always_comb begin
    logic neg;
    neg   = dt_q[0] < 0;
    det_a = neg ? -dt_q[0] : dt_q[0];
    un_a  = neg ? -dt_q[1] : dt_q[1];
    vn_a  = neg ? -dt_q[2] : dt_q[2];
    tn_a  = neg ? -dt_q[3] : dt_q[3];
    ck_d.miss = (det_a <= $signed(IW'(det_eps_q))) || (un_a < 0) || (un_a > det_a) ||
                (vn_a < 0) ||
                (({1'b0, un_a} + {1'b0, vn_a}) > {1'b0, det_a}) || (tn_a <= 0);
    // quotient reaches 2^63 when tn * 2^F >= det * 2^63
    ck_d.sat  = PW'(unsigned'(tn_a)) >= (PW'(unsigned'(det_a)) << (IW - 1 - FRAC_BITS));
    ck_d.det  = det_a[IW-2:0];
    ck_d.tn   = tn_a[IW-2:0];
    ck_d.rem  = unsigned'(tn_a) >> (IW - 1 - FRAC_BITS);
    ck_d.q    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[S_CK]) dv_q[0] <= ck_d;
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int BI = NDIV - 1 - j;
    div_t          nx;
    logic          nb;
    logic [IW-1:0] rs;
    logic          ge;

    if (BI >= FRAC_BITS) begin : g_num
      assign nb = dv_q[j].tn[BI-FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    always_comb begin
      nx     = dv_q[j];
      rs     = {dv_q[j].rem[IW-2:0], nb};
      ge     = rs >= {1'b0, dv_q[j].det};
      nx.rem = ge ? rs - {1'b0, dv_q[j].det} : rs;
      nx.q   = {dv_q[j].q[IW-3:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en[S_DV0+j]) dv_q[j+1] <= nx;
    end
  end

  // ---------------- hit point ----------------
  s64_t  tq;
  logic  miss_fm;
  logic  miss_q [3];
  s128_t fp_p [3];
  s64_t  fq_q [3];

  assign tq      = dv_q[NDIV].sat ? SMAX : s64_t'({1'b0, dv_q[NDIV].q});
  assign miss_fm = dv_q[NDIV].miss ||
                   (!dv_q[NDIV].sat && ({1'b0, dv_q[NDIV].q} <= IW'(t_eps_q)));

  for (genvar i = 0; i < 3; i++) begin : g_fin
    rti_mul #(.AW(C), .BW(IW)) u_mul (
      .clk_i, .en_i({en[S_FM2], en[S_FM1]}),
      .a_i(ray_q[S_FM1-1].dir[i]), .b_i(tq),
      .p_o(fp_p[i])
    );
  end

  logic [2:0][C-1:0] data_q;
  logic              hit_q;

  always_ff @(posedge clk_i) begin
    if (en[S_FM1]) miss_q[0] <= miss_fm;
    if (en[S_FM2]) miss_q[1] <= miss_q[0];
    if (en[S_FQ]) begin
      miss_q[2] <= miss_q[1];
      for (int i = 0; i < 3; i++) fq_q[i] <= mulq_sat(fp_p[i], FRAC_BITS);
    end
    if (en[S_OUT]) begin
      hit_q <= !miss_q[2];
      for (int i = 0; i < 3; i++) begin
        s64_t r;
        r = sat_add(IW'($signed(ray_q[S_FQ].org[i])), fq_q[i]);
        if (r > CMAX_W) r = CMAX_W;
        if (r < CMIN_W) r = CMIN_W;
        data_q[i] <= miss_q[2] ? '0 : r[C-1:0];
      end
    end
  end

  assign m_axis_tvalid = v_q[S_OUT];
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OutTw'(data_q);

endmodule

FILE: sv/rti_checker.sv
module rti_checker import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int OutTw = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutTw-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready
);

`include "ray_triangle_intersect_top_assert.svh"

  // a stalled result word holds
`RTI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
`RTI_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a miss carries an all-zero point
`RTI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

  // register read-back after a write to the same address
`RTI_ASSERT_NEXT(a_reg_rb, psel && penable && pwrite && pready, (paddr[2] != $past(paddr[2])) || (prdata[15:0] == $past(pwdata[15:0])))

endmodule

bind ray_triangle_intersect_top rti_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_rti_checker (.*);
